### rtl/sid_pkg.sv
// Shared types and defaults for the descending insertion sorter.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package sid_pkg;

  // Port payload width, fixed by the channel definition
  localparam int FIELD_W     = 32;
  // Defaults for the top-level parameters
  localparam int DEPTH_DEF   = 32;
  localparam int KEY_W_DEF   = 32;

  // Controller -> datapath commands
  typedef struct packed {
    logic insert;  // write the incoming key into its sorted slot
    logic drop;    // store full: discard key, mark overflow
    logic pop;     // move head key into the output register, shift up
  } sid_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic full;      // store holds DEPTH keys
    logic last_one;  // exactly one key left
    logic out_free;  // output register can take a new item this cycle
    logic dropped;   // a key of the current set was discarded
  } sid_stat_t;

endpackage

`default_nettype wire

### rtl/sid_ifs.sv
// Valid/ready channel interfaces for the sorter: key input and sorted output.
// Payload widths come from sid_pkg.
`default_nettype none

interface sid_in_if;
  logic                        valid;
  logic                        ready;
  logic [sid_pkg::FIELD_W-1:0] key_value;
  logic                        end_of_set;

  modport source (output valid, key_value, end_of_set, input ready);
  modport sink   (input valid, key_value, end_of_set, output ready);
endinterface

interface sid_out_if;
  logic                        valid;
  logic                        ready;
  logic [sid_pkg::FIELD_W-1:0] sorted_key;
  logic                        last_out;
  logic                        overflow;

  modport source (output valid, sorted_key, last_out, overflow, input ready);
  modport sink   (input valid, sorted_key, last_out, overflow, output ready);
endinterface

`default_nettype wire

### rtl/sid_datapath.sv
// Sorted key store (row of compare/shift cells), fill count, overflow flag
// and output register. Driven by sid_ctrl commands; uses sid_pkg types.
`default_nettype none

module sid_datapath #(
  parameter int DEPTH = sid_pkg::DEPTH_DEF,
  parameter int KEY_W = sid_pkg::KEY_W_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [sid_pkg::FIELD_W-1:0] key_in,
  input  wire sid_pkg::sid_cmd_t           cmd,
  output sid_pkg::sid_stat_t               stat,
  sid_out_if.source                        out_ch
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [KEY_W-1:0] entry_r   [DEPTH];
  logic [KEY_W-1:0] entry_nxt [DEPTH];
  logic [CW-1:0]    fill_r, fill_nxt;
  logic             dropped_r, dropped_nxt;
  logic             out_valid_r;
  logic [sid_pkg::FIELD_W-1:0] out_key_r;
  logic             out_last_r, out_ovf_r;
  logic [KEY_W-1:0] key;
  logic [DEPTH-1:0] keep;  // held key stays: valid and new key <= it

  // low KEY_W bits of the port field, zero-extended when KEY_W is wider
  assign key = KEY_W'({{KEY_W{1'b0}}, key_in});

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CW'(i) < fill_r) && ($signed(key) <= $signed(entry_r[i]));
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_nxt[i] = entry_r[i];
      if (cmd.insert) begin
        if (keep[i]) begin
          entry_nxt[i] = entry_r[i];
        end else if (i == 0) begin
          entry_nxt[i] = key;
        end else if (keep[i-1]) begin
          entry_nxt[i] = key;
        end else begin
          entry_nxt[i] = entry_r[i-1];
        end
      end else if (cmd.pop && i < DEPTH - 1) begin
        entry_nxt[i] = entry_r[i+1];
      end
    end
  end

  always_comb begin
    fill_nxt    = fill_r;
    dropped_nxt = dropped_r;
    if (cmd.insert) fill_nxt = fill_r + CW'(1);
    if (cmd.drop)   dropped_nxt = 1'b1;
    if (cmd.pop) begin
      fill_nxt = fill_r - CW'(1);
      if (stat.last_one) dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_r[i] <= entry_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      dropped_r <= dropped_nxt;
      if (cmd.pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_key_r  <= sid_pkg::FIELD_W'({{sid_pkg::FIELD_W{1'b0}}, entry_r[0]});
      out_last_r <= stat.last_one;
      out_ovf_r  <= dropped_r;
    end
  end

  assign stat.full     = (fill_r == CW'(DEPTH));
  assign stat.last_one = (fill_r == CW'(1));
  assign stat.out_free = !out_valid_r || out_ch.ready;
  assign stat.dropped  = dropped_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sorted_key = out_key_r;
  assign out_ch.last_out   = out_last_r;
  assign out_ch.overflow   = out_ovf_r;

endmodule

`default_nettype wire

### rtl/sid_ctrl.sv
// Sequencer for the sorter: accepts keys, then drains the store on end of set.
// Talks to sid_datapath through sid_pkg command/status structs.
`default_nettype none

module sid_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_ready,
  input  wire sid_pkg::sid_stat_t stat,
  output sid_pkg::sid_cmd_t       cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_r, state_nxt;
  logic take;

  assign in_ready = (state_r == ST_IDLE);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd.insert = 1'b0;
    cmd.drop   = 1'b0;
    cmd.pop    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.insert = take && !stat.full;
        cmd.drop   = take && stat.full;
        if (take && in_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.pop = stat.out_free;
        if (stat.out_free && stat.last_one) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/sorted_insert_descending_core.sv
// Top level of the descending insertion sorter: sid_ctrl plus sid_datapath.
// Depends on sid_pkg and the channel interfaces in sid_ifs.sv.
`default_nettype none

// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    key_value[31:0] signed, end_of_set
// out_ch    out  valid/ready    sorted_key[31:0] signed, last_out, overflow
//
// Insert: one key per cycle outside the drain; every cell compares against the new key in
//   parallel and shifts down in the same cycle.
// Emit: after the end_of_set key, keys leave one per cycle while out_ready
//   is high, through the output register; input is held off until the last
//   key has left the store, then keys are taken while the final item waits.
// Reset clears the fill count, overflow flag, output valid and the sequencer;
//   key storage is not cleared. out_ready low just pauses the drain.

module sorted_insert_descending_core #(
  parameter int DEPTH = sid_pkg::DEPTH_DEF,  // keys held, 2..64
  parameter int KEY_W = sid_pkg::KEY_W_DEF   // stored key width, 8..64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sid_in_if.sink    in_ch,
  sid_out_if.source out_ch
);

  sid_pkg::sid_cmd_t  cmd;
  sid_pkg::sid_stat_t stat;

  // sequencer: accept phase / drain phase
  sid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.end_of_set),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // cell row, counters and output register
  sid_datapath #(
    .DEPTH (DEPTH),
    .KEY_W (KEY_W)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .key_in (in_ch.key_value),
    .cmd    (cmd),
    .stat   (stat),
    .out_ch (out_ch)
  );

  // Popping the final key must present a last item next cycle.
  a_last_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop && stat.last_one |=> out_ch.valid && out_ch.last_out)
    else $error("final pop did not produce a last item");

  // A key taken while full must leave the overflow flag set.
  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && stat.full |=> stat.dropped)
    else $error("dropped key not flagged");

  // While a non-final item of a set is pending, no new key may be taken.
  a_no_take_mid_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last_out |-> !in_ch.ready)
    else $error("input accepted during drain");

  // Insert, drop and pop are mutually exclusive.
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.insert, cmd.drop, cmd.pop}) <= 1)
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire
